[sv/sas_pkg.sv]
package sas_pkg;

	typedef enum logic [2:0] {
		CMD_DEFINE  = 3'd0,
		CMD_CREATE  = 3'd1,
		CMD_DESTROY = 3'd2,
		CMD_TICK    = 3'd3,
		CMD_QUERY   = 3'd4
	} cmd_code_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_USED = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] texture_handle;
		logic [7:0]  frame_count;
		logic [7:0]  frames_per_row;
		logic [7:0]  first_column;
		logic [7:0]  first_row;
		logic        looping;
		logic [23:0] frame_period;
		logic [7:0]  pattern_slot;
		logic [8:0]  player_slot;
		logic [23:0] elapsed;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [8:0]  slot_taken;
		logic [7:0]  sheet_column;
		logic [8:0]  sheet_row;
		logic [7:0]  column_offset;
		logic [15:0] texture_out;
		logic        stopped;
	} rsp_t;

	// one pattern slot: timing and sheet layout side by side
	typedef struct packed {
		logic        valid;
		logic [23:0] period;
		logic [7:0]  count;
		logic        loop;
		logic [15:0] texture;
		logic [7:0]  per_row;
		logic [7:0]  col0;
		logic [7:0]  row0;
	} pat_entry_t;

endpackage

[sv/sprite_animation_sequencer_top.sv]
// Sprite animation sequencer.
// Items arrive on the cmd channel (cmd_valid / cmd_stall / cmd) and each one
// gives exactly one response item on the rsp channel (rsp_valid / rsp_stall /
// rsp). An item is taken at a rising edge with valid high and stall low.
// Patterns and players live in two synchronous memories (registered read);
// all work is read, modify and write back on those memories.
// Work per item, from acceptance to the response register:
//   define   : scans the pattern slots for the first free one (FULL when none)
//   create   : checks the pattern slot, then scans the player slots likewise
//   destroy  : reads the player slot and clears it; query : player read,
//              pattern read and an eight-step divider for sheet column and row
//   tick     : a four-stage pipeline streaming every player slot through the player memory port once
// One item is worked at a time; cmd_stall is high from acceptance until the
// response has moved into the output register. A waiting response does not
// block the next item, but a second response waits for the first to leave.
// After reset a clearing pass over every slot address of both memories
// invalidates them; cmd_stall stays high throughout it.
// While rsp_stall is high the response holds steady.
module sprite_animation_sequencer_top #(
	parameter int PATTERN_SLOTS = 256,
	parameter int PLAYER_SLOTS  = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  sas_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sas_pkg::rsp_t rsp
);
	import sas_pkg::*;

	localparam int PAT_AW    = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
	localparam int PLY_AW    = (PLAYER_SLOTS > 1) ? $clog2(PLAYER_SLOTS) : 1;
	localparam int MAX_SLOTS = (PATTERN_SLOTS > PLAYER_SLOTS) ? PATTERN_SLOTS : PLAYER_SLOTS;
	localparam int SCAN_W    = $clog2(MAX_SLOTS + 1);
	localparam int RSP_W     = $bits(rsp_t);

	typedef struct packed {
		logic              valid;
		logic [PAT_AW-1:0] pattern;
		logic [7:0]        frame;
		logic              stopped;
		logic [31:0]       acc;
	} ply_entry_t;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_CRPAT = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_PLRD  = 9'b000010000,
		S_QPAT  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_TICK  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// memories
	pat_entry_t pat_mem [PATTERN_SLOTS];
	ply_entry_t ply_mem [PLAYER_SLOTS];
	pat_entry_t pat_rd_q, pat_wdata;
	ply_entry_t ply_rd_q, ply_wdata;
	logic [PAT_AW-1:0] pat_raddr, pat_waddr;
	logic [PLY_AW-1:0] ply_raddr, ply_waddr;
	logic pat_we, ply_we;

	// control
	logic [SCAN_W-1:0] scan_q, clr_q, scan_end;
	logic v_s1, v_s2, v_s3;
	logic [SCAN_W-1:0] idx_s1;
	logic [PLY_AW-1:0] idx_s2, idx_s3;
	ply_entry_t pl_s2, pl_s3;
	logic [2:0] step_q;
	logic rsp_valid_q;

	// payload
	cmd_t item_q;
	rsp_t res_q, rsp_q;
	logic [7:0] div_q, quot_q, rem_q, row0_q;
	logic stop_q;

	logic accept, is_define, issue, found, scan_full, tick_end, can_load;
	logic pat_in_range, ply_in_range;
	logic [1:0] init_status;
	logic [8:0] trial;
	logic [7:0] rem_n, quot_n;
	logic adv;
	logic [8:0] next_frame;
	logic [32:0] sum;
	ply_entry_t pl_adv;

	assign accept       = (state_q == S_IDLE) && cmd_valid;
	assign cmd_stall    = (state_q != S_IDLE);
	assign is_define    = (item_q.command == CMD_DEFINE);
	assign scan_end     = is_define ? SCAN_W'(PATTERN_SLOTS) : SCAN_W'(PLAYER_SLOTS);
	assign issue        = (scan_q != scan_end);
	assign found        = (state_q == S_SCAN) && v_s1 &&
	                      (is_define ? !pat_rd_q.valid : !ply_rd_q.valid);
	assign scan_full    = (state_q == S_SCAN) && !found && !issue && !v_s1;
	assign tick_end     = (state_q == S_TICK) && !issue && !v_s1 && !v_s2 && !v_s3;
	assign can_load     = !rsp_valid_q || !rsp_stall;
	assign pat_in_range = 13'(cmd.pattern_slot) < 13'(PATTERN_SLOTS);
	assign ply_in_range = 13'(cmd.player_slot) < 13'(PLAYER_SLOTS);
	assign init_status  = ((cmd.command == CMD_CREATE && !pat_in_range) ||
	                       ((cmd.command == CMD_DESTROY || cmd.command == CMD_QUERY) &&
	                        !ply_in_range)) ? ST_NOT_USED : ST_OK;

	// one restoring division step
	assign trial  = {rem_q, quot_q[7]};
	assign rem_n  = (trial >= {1'b0, div_q}) ? 8'(trial - {1'b0, div_q}) : trial[7:0];
	assign quot_n = {quot_q[6:0], (trial >= {1'b0, div_q})};

	// tick stage three: frame advance against the pattern period
	always_comb begin
		pl_adv     = pl_s2;
		adv        = pl_s2.acc >= {8'd0, pat_rd_q.period};
		next_frame = {1'b0, pl_s2.frame} + 9'd1;
		if (adv) begin
			if (next_frame >= {1'b0, pat_rd_q.count}) begin
				if (pat_rd_q.loop) begin
					pl_adv.frame = 8'd0;
				end else begin
					pl_adv.frame   = pat_rd_q.count - 8'd1;
					pl_adv.stopped = 1'b1;
				end
			end else begin
				pl_adv.frame = next_frame[7:0];
			end
			pl_adv.acc = pl_s2.acc - {8'd0, pat_rd_q.period};
		end
	end

	// tick stage four: saturating add of the elapsed time
	assign sum = {1'b0, pl_s3.acc} + 33'(item_q.elapsed);

	// read addresses
	always_comb begin
		pat_raddr = PAT_AW'(cmd.pattern_slot);
		ply_raddr = PLY_AW'(cmd.player_slot);
		if (state_q == S_SCAN || state_q == S_TICK) begin
			pat_raddr = scan_q[PAT_AW-1:0];
			ply_raddr = scan_q[PLY_AW-1:0];
		end
		if (state_q == S_PLRD || state_q == S_TICK) begin
			pat_raddr = ply_rd_q.pattern;
		end
	end

	// write ports
	always_comb begin
		pat_we            = 1'b0;
		pat_waddr         = idx_s1[PAT_AW-1:0];
		pat_wdata.valid   = 1'b1;
		pat_wdata.period  = item_q.frame_period;
		pat_wdata.count   = (item_q.frame_count == 8'd0) ? 8'd1 : item_q.frame_count;
		pat_wdata.loop    = item_q.looping;
		pat_wdata.texture = item_q.texture_handle;
		pat_wdata.per_row = (item_q.frames_per_row == 8'd0) ? 8'd1 : item_q.frames_per_row;
		pat_wdata.col0    = item_q.first_column;
		pat_wdata.row0    = item_q.first_row;
		ply_we            = 1'b0;
		ply_waddr         = idx_s1[PLY_AW-1:0];
		ply_wdata.valid   = 1'b1;
		ply_wdata.pattern = PAT_AW'(item_q.pattern_slot);
		ply_wdata.frame   = 8'd0;
		ply_wdata.stopped = 1'b0;
		ply_wdata.acc     = 32'd0;
		unique case (state_q)
			S_CLEAR: begin
				pat_we    = clr_q < SCAN_W'(PATTERN_SLOTS);
				ply_we    = clr_q < SCAN_W'(PLAYER_SLOTS);
				pat_waddr = clr_q[PAT_AW-1:0];
				ply_waddr = clr_q[PLY_AW-1:0];
				pat_wdata = '0;
				ply_wdata = '0;
			end
			S_SCAN: begin
				pat_we = found && is_define;
				ply_we = found && !is_define;
			end
			S_PLRD: begin
				ply_we          = ply_rd_q.valid && (item_q.command == CMD_DESTROY);
				ply_waddr       = PLY_AW'(item_q.player_slot);
				ply_wdata       = ply_rd_q;
				ply_wdata.valid = 1'b0;
			end
			S_TICK: begin
				ply_we        = v_s3;
				ply_waddr     = idx_s3;
				ply_wdata     = pl_s3;
				ply_wdata.acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_waddr] <= pat_wdata;
		end
		pat_rd_q <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk) begin
		if (ply_we) begin
			ply_mem[ply_waddr] <= ply_wdata;
		end
		ply_rd_q <= ply_mem[ply_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == SCAN_W'(MAX_SLOTS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					case (cmd.command)
						CMD_DEFINE:  state_d = S_SCAN;
						CMD_CREATE:  state_d = pat_in_range ? S_CRPAT : S_DONE;
						CMD_DESTROY,
						CMD_QUERY:   state_d = ply_in_range ? S_PLRD : S_DONE;
						CMD_TICK:    state_d = S_TICK;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_CRPAT: state_d = pat_rd_q.valid ? S_SCAN : S_DONE;
			S_SCAN:  if (found || scan_full) state_d = S_DONE;
			S_PLRD: begin
				if (ply_rd_q.valid && item_q.command == CMD_QUERY) state_d = S_QPAT;
				else state_d = S_DONE;
			end
			S_QPAT:  state_d = S_DIV;
			S_DIV:   if (step_q == 3'd7) state_d = S_DONE;
			S_TICK:  if (tick_end) state_d = S_DONE;
			S_DONE:  if (can_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			scan_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SCAN_W'(1);
			end
			if (accept) begin
				scan_q <= '0;
			end else if ((state_q == S_SCAN || state_q == S_TICK) && issue) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			v_s1 <= (state_q == S_SCAN || state_q == S_TICK) && issue && !found;
			v_s2 <= (state_q == S_TICK) && v_s1 && ply_rd_q.valid;
			v_s3 <= (state_q == S_TICK) && v_s2;
			if (state_q == S_QPAT) begin
				step_q <= '0;
			end else if (state_q == S_DIV) begin
				step_q <= step_q + 3'd1;
			end
			// hand the response over; drop it once taken
			if (state_q == S_DONE && can_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		pl_s2  <= ply_rd_q;
		idx_s2 <= idx_s1[PLY_AW-1:0];
		pl_s3  <= pl_adv;
		idx_s3 <= idx_s2;
		if (accept) begin
			item_q <= cmd;
			res_q  <= {init_status, {(RSP_W-2){1'b0}}};
		end
		if (state_q == S_CRPAT && !pat_rd_q.valid) begin
			res_q.status <= ST_NOT_USED;
		end
		if (found) begin
			res_q.status     <= ST_OK;
			res_q.slot_taken <= 9'(idx_s1);
		end
		if (scan_full) begin
			res_q.status <= ST_FULL;
		end
		if (state_q == S_PLRD) begin
			res_q.status <= ply_rd_q.valid ? ST_OK : ST_NOT_USED;
			quot_q       <= ply_rd_q.frame;
			stop_q       <= ply_rd_q.stopped;
		end
		if (state_q == S_QPAT) begin
			div_q               <= pat_rd_q.per_row;
			row0_q              <= pat_rd_q.row0;
			rem_q               <= 8'd0;
			res_q.column_offset <= pat_rd_q.col0;
			res_q.texture_out   <= pat_rd_q.texture;
			res_q.stopped       <= stop_q;
		end
		if (state_q == S_DIV) begin
			rem_q  <= rem_n;
			quot_q <= quot_n;
			if (step_q == 3'd7) begin
				res_q.sheet_column <= rem_n;
				res_q.sheet_row    <= {1'b0, row0_q} + {1'b0, quot_n};
			end
		end
		if (state_q == S_DONE && can_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/sas_checker.sv]
module sas_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input sas_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input sas_pkg::rsp_t rsp
);
	import sas_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second item taken while one is in work");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.slot_taken == 9'd0 && rsp.texture_out == 16'd0 && !rsp.stopped)
		else $error("failed response carries data");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response without an item in work");

endmodule

bind sprite_animation_sequencer_top sas_checker u_sas_checker (.*);

[sim/sprite_animation_sequencer_top_test.sv]
`timescale 1ns / 100ps

module sprite_animation_sequencer_top_test;
	import sas_pkg::*;

	localparam int PAT_N = 256;
	localparam int PLY_N = 512;
	localparam longint CYCLE_LIMIT = 64'd6000000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	sprite_animation_sequencer_top dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// shadow copy of the pattern and player tables
	pat_entry_t pat_tab[PAT_N];
	logic       ply_valid[PLY_N];
	logic [7:0] ply_pattern[PLY_N];
	logic [7:0] ply_frame[PLY_N];
	logic       ply_stopped[PLY_N];
	logic [31:0] ply_acc[PLY_N];

	rsp_t pending_rsp[$];
	int   mismatches;
	longint cycles;
	int   send_idle_pct;
	int   recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// timeout guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("sprite_animation_sequencer_top regression: fail");
				$finish;
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// work out the response for one accepted item and update the shadow tables
	function automatic rsp_t animate_step(input cmd_t c);
		rsp_t r;
		logic [8:0] fpr;
		logic [32:0] sum;
		logic [8:0] nxt;
		pat_entry_t pt;
		r = '0;
		case (c.command)
			CMD_DEFINE: begin
				r.status = ST_FULL;
				for (int i = 0; i < PAT_N; i++) begin
					if (!pat_tab[i].valid) begin
						pat_tab[i].valid   = 1'b1;
						pat_tab[i].texture = c.texture_handle;
						pat_tab[i].count   = (c.frame_count == 0) ? 8'd1 : c.frame_count;
						pat_tab[i].per_row = (c.frames_per_row == 0) ? 8'd1 : c.frames_per_row;
						pat_tab[i].col0    = c.first_column;
						pat_tab[i].row0    = c.first_row;
						pat_tab[i].loop    = c.looping;
						pat_tab[i].period  = c.frame_period;
						r.status     = ST_OK;
						r.slot_taken = 9'(i);
						break;
					end
				end
			end
			CMD_CREATE: begin
				if (!pat_tab[c.pattern_slot].valid) begin
					r.status = ST_NOT_USED;
				end else begin
					r.status = ST_FULL;
					for (int i = 0; i < PLY_N; i++) begin
						if (!ply_valid[i]) begin
							ply_valid[i]   = 1'b1;
							ply_pattern[i] = c.pattern_slot;
							ply_frame[i]   = 8'd0;
							ply_stopped[i] = 1'b0;
							ply_acc[i]     = 32'd0;
							r.status     = ST_OK;
							r.slot_taken = 9'(i);
							break;
						end
					end
				end
			end
			CMD_DESTROY: begin
				if (!ply_valid[c.player_slot])
					r.status = ST_NOT_USED;
				else
					ply_valid[c.player_slot] = 1'b0;
			end
			CMD_TICK: begin
				for (int i = 0; i < PLY_N; i++) begin
					if (ply_valid[i]) begin
						pt = pat_tab[ply_pattern[i]];
						// advance first, then accumulate
						if (ply_acc[i] >= {8'd0, pt.period}) begin
							nxt = {1'b0, ply_frame[i]} + 9'd1;
							if (nxt >= {1'b0, pt.count}) begin
								if (pt.loop) begin
									nxt = 9'd0;
								end else begin
									nxt = {1'b0, pt.count} - 9'd1;
									ply_stopped[i] = 1'b1;
								end
							end
							ply_frame[i] = nxt[7:0];
							ply_acc[i] = ply_acc[i] - {8'd0, pt.period};
						end
						sum = {1'b0, ply_acc[i]} + {9'd0, c.elapsed};
						ply_acc[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					end
				end
			end
			CMD_QUERY: begin
				if (!ply_valid[c.player_slot]) begin
					r.status = ST_NOT_USED;
				end else begin
					pt  = pat_tab[ply_pattern[c.player_slot]];
					fpr = {1'b0, pt.per_row};
					r.sheet_column  = 8'({1'b0, ply_frame[c.player_slot]} % fpr);
					r.sheet_row     = {1'b0, pt.row0} + {1'b0, ply_frame[c.player_slot]} / fpr;
					r.column_offset = pt.col0;
					r.texture_out   = pt.texture;
					r.stopped       = ply_stopped[c.player_slot];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// drive one item, hold it until taken, then predict
	task automatic send_item(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pending_rsp.push_back(animate_step(c));
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall and compare with the oldest expectation
	initial begin
		rsp_t want;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected item", 32'(rsp), 0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.slot_taken !== want.slot_taken)
						report_mismatch("slot_taken", 32'(rsp.slot_taken),
							32'(want.slot_taken));
					if (rsp.sheet_column !== want.sheet_column)
						report_mismatch("sheet_column", 32'(rsp.sheet_column),
							32'(want.sheet_column));
					if (rsp.sheet_row !== want.sheet_row)
						report_mismatch("sheet_row", 32'(rsp.sheet_row),
							32'(want.sheet_row));
					if (rsp.column_offset !== want.column_offset)
						report_mismatch("column_offset", 32'(rsp.column_offset),
							32'(want.column_offset));
					if (rsp.texture_out !== want.texture_out)
						report_mismatch("texture_out", 32'(rsp.texture_out),
							32'(want.texture_out));
					if (rsp.stopped !== want.stopped)
						report_mismatch("stopped", 32'(rsp.stopped), 32'(want.stopped));
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic cmd_t random_fields();
		cmd_t c;
		c = '0;
		c.texture_handle = 16'($urandom);
		c.frame_count    = 8'($urandom);
		c.frames_per_row = 8'($urandom);
		c.first_column   = 8'($urandom);
		c.first_row      = 8'($urandom);
		c.looping        = 1'($urandom);
		c.frame_period   = 24'($urandom);
		c.pattern_slot   = 8'($urandom);
		c.player_slot    = 9'($urandom);
		c.elapsed        = 24'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_define(input logic [7:0] cnt, input logic [7:0] fpr,
			input logic lp, input logic [23:0] per);
		cmd_t c;
		c = random_fields();
		c.command = CMD_DEFINE;
		c.frame_count = cnt;
		c.frames_per_row = fpr;
		c.looping = lp;
		c.frame_period = per;
		return c;
	endfunction

	function automatic cmd_t make_op(input cmd_code_t op, input logic [8:0] slot,
			input logic [23:0] el);
		cmd_t c;
		c = random_fields();
		c.command = op;
		c.pattern_slot = slot[7:0];
		c.player_slot = slot;
		c.elapsed = el;
		return c;
	endfunction

	// extremes, zero counts, unused slots, unknown commands, saturation
	task automatic test_directed();
		cmd_t c;
		send_item(make_op(CMD_QUERY, 9'd0, 24'd0));
		send_item(make_op(CMD_DESTROY, 9'd511, 24'd0));
		send_item(make_op(CMD_CREATE, 9'd0, 24'd0));
		send_item(make_define(8'd0, 8'd0, 1'b0, 24'd0));
		send_item(make_define(8'd255, 8'd255, 1'b1, 24'hFFFFFF));
		send_item(make_define(8'd3, 8'd2, 1'b0, 24'h010000));
		c = make_define(8'd5, 8'd1, 1'b1, 24'd0);
		c.texture_handle = 16'hFFFF; c.first_column = 8'hFF; c.first_row = 8'hFF;
		send_item(c);
		for (int p = 0; p < 4; p++) send_item(make_op(CMD_CREATE, 9'(p), 24'd0));
		send_item(make_op(CMD_CREATE, 9'd255, 24'd0));
		send_item(make_op(CMD_TICK, 9'd0, 24'hFFFFFF));
		send_item(make_op(CMD_TICK, 9'd0, 24'd0));
		send_item(make_op(CMD_TICK, 9'd0, 24'h020000));
		send_item(make_op(CMD_TICK, 9'd0, 24'h020000));
		for (int q = 0; q < 4; q++) send_item(make_op(CMD_QUERY, 9'(q), 24'd0));
		send_item(make_op(CMD_DESTROY, 9'd1, 24'd0));
		send_item(make_op(CMD_QUERY, 9'd1, 24'd0));
		for (int u = 5; u < 8; u++) begin
			c = random_fields();
			c.command = cmd_code_t'(u);
			send_item(c);
		end
	endtask

	// fill the player table to full, then free part of it again
	task automatic test_player_full();
		for (int i = 0; i < PLY_N - 3; i++) send_item(make_op(CMD_CREATE, 9'd3, 24'd0));
		send_item(make_op(CMD_CREATE, 9'd2, 24'd0));
		send_item(make_op(CMD_TICK, 9'd0, 24'h008000));
		send_item(make_op(CMD_QUERY, 9'd511, 24'd0));
		for (int i = 8; i < 64; i++) send_item(make_op(CMD_DESTROY, 9'(i), 24'd0));
	endtask

	// pause the sender until every expected item has come back
	task automatic test_drain_pause();
		wait_drained();
		send_item(make_op(CMD_QUERY, 9'd0, 24'd0));
	endtask

	// mostly well-formed traffic over a small set of players
	task automatic test_random(input int n);
		cmd_t c;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				c = random_fields();
				c.command = CMD_DEFINE;
				if ($urandom_range(1)) c.frame_count = 8'($urandom_range(4));
				if ($urandom_range(1)) c.frame_period = 24'($urandom_range(24'h030000));
			end else if (r < 30) begin
				c = make_op(CMD_CREATE, 9'($urandom_range(15)), 24'd0);
				if ($urandom_range(9) == 0) c.pattern_slot = 8'($urandom);
			end else if (r < 42) begin
				c = make_op(CMD_DESTROY, 9'($urandom_range(31)), 24'd0);
				if ($urandom_range(9) == 0) c.player_slot = 9'($urandom);
			end else if (r < 62) begin
				c = make_op(CMD_TICK, 9'd0, 24'($urandom_range(24'h040000)));
				if ($urandom_range(9) == 0) c.elapsed = 24'($urandom);
			end else if (r < 97) begin
				c = make_op(CMD_QUERY, 9'($urandom_range(31)), 24'd0);
				if ($urandom_range(9) == 0) c.player_slot = 9'($urandom);
			end else begin
				c = random_fields();
				c.command = cmd_code_t'(3'($urandom_range(5, 7)));
			end
			send_item(c);
		end
	endtask

	// fill the pattern table last, since patterns never free
	task automatic test_pattern_full();
		int used;
		used = 0;
		for (int i = 0; i < PAT_N; i++) if (pat_tab[i].valid) used++;
		for (int i = used; i <= PAT_N; i++)
			send_item(make_define(8'($urandom), 8'($urandom), 1'($urandom), 24'($urandom)));
		send_item(make_op(CMD_CREATE, 9'd255, 24'd0));
		send_item(make_op(CMD_QUERY, 9'd0, 24'd0));
	endtask

	initial begin
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < PAT_N; i++) pat_tab[i] = '0;
		for (int i = 0; i < PLY_N; i++) begin
			ply_valid[i] = 1'b0; ply_pattern[i] = '0; ply_frame[i] = '0;
			ply_stopped[i] = 1'b0; ply_acc[i] = '0;
		end
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_player_full();
		test_drain_pause();
		send_idle_pct = 61;
		test_random(100);
		send_idle_pct = 0; recv_stall_pct = 61;
		test_random(100);
		send_idle_pct = 35; recv_stall_pct = 35;
		test_random(100);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(40);
		test_pattern_full();

		// hold until every response is back, then let the pipeline settle
		wait_drained();
		repeat (PLY_N + 20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("sprite_animation_sequencer_top regression: pass");
		else
			$display("sprite_animation_sequencer_top regression: fail");
		$finish;
	end

endmodule
